@@ sv/dbs_pkg.sv @@
// ----------------------------------------------------------------------------
// dbs_pkg
// shared constants and types for the descending batch sorter
// ----------------------------------------------------------------------------
package dbs_pkg;

    // capacity of the sorting chain and word width
    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // controller states
    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

endpackage

@@ sv/dbs_cell.sv @@
// ----------------------------------------------------------------------------
// dbs_cell
// one slot of the insertion chain: holds a word and its occupancy bit
// ----------------------------------------------------------------------------
module dbs_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dbs_pkg::t_cell_ctl                i_ctl,
    input  logic signed [dbs_pkg::DATA_W-1:0] i_new_value,
    input  logic signed [dbs_pkg::DATA_W-1:0] i_prev_value,
    input  logic                              i_prev_valid,
    input  logic                              i_prev_take,
    input  logic signed [dbs_pkg::DATA_W-1:0] i_next_value,
    input  logic                              i_next_valid,
    output logic signed [dbs_pkg::DATA_W-1:0] o_value,
    output logic                              o_valid,
    output logic                              o_take
);

    logic signed [dbs_pkg::DATA_W-1:0] r_value;
    logic                              r_valid;
    logic signed [dbs_pkg::DATA_W-1:0] n_value;
    logic                              n_valid;

    // new word belongs at or above this slot when the slot is empty or the word beats the held word
    assign o_take = !r_valid || (i_new_value > r_value);

    // next contents: insert shifts the tail down, emit shifts towards slot 0
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end else if (i_ctl.insert && o_take) begin
            n_value = i_prev_take ? i_prev_value : i_new_value;
            n_valid = r_valid | i_prev_valid;
        end
    end

    // occupancy bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // held word
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

@@ sv/descending_batch_sorter_top.sv @@
// ----------------------------------------------------------------------------
// descending_batch_sorter_top
// collects a batch of signed words and returns them largest first
// ----------------------------------------------------------------------------
// Usage
//   Input: drive i_value and i_last with start high; the word is taken at a
//   clock edge where start is high and busy is low. While loading, busy is
//   low and one word is taken every cycle. Each word is placed in order in a
//   chain of DEPTH cells as it arrives; words beyond DEPTH are dropped.
//   Output: the word flagged i_last closes the batch. From the next cycle
//   busy is high and the batch leaves one word per cycle, largest first, on
//   o_value_res with o_res_valid high for one cycle each. o_last_res marks
//   the final word, o_overflow is high on every word of a batch that lost
//   words. The result stream shifts out of slot 0 of the chain.
//   The first result appears in the cycle after the closing word is taken.
//   The chain accepts no new word while it shifts out.
//   The receiver cannot stall: every result is shown for exactly one cycle.
//   Reset (synchronous, active low) empties the chain and clears the flags.
// ----------------------------------------------------------------------------
module descending_batch_sorter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [dbs_pkg::DATA_W-1:0] i_value,
    input  logic                              i_last,
    output logic                              o_res_valid,
    output logic signed [dbs_pkg::DATA_W-1:0] o_value_res,
    output logic                              o_last_res,
    output logic                              o_overflow
);

    dbs_pkg::t_state              r_state;
    dbs_pkg::t_state              n_state;
    logic [dbs_pkg::CNT_W-1:0]    r_count;
    logic [dbs_pkg::CNT_W-1:0]    n_count;
    logic                         r_dropped;
    logic                         n_dropped;
    logic                         w_accept;
    logic                         w_room;
    logic                         w_emit;
    dbs_pkg::t_cell_ctl           w_ctl;

    logic signed [dbs_pkg::DATA_W-1:0] w_value [dbs_pkg::DEPTH];
    logic                              w_valid [dbs_pkg::DEPTH];
    logic                              w_take  [dbs_pkg::DEPTH];

    assign w_accept = start && !busy;
    assign w_room   = (r_count < dbs_pkg::CNT_W'(dbs_pkg::DEPTH));

    // output and control decode
    always_comb begin
        busy        = 1'b0;
        w_emit      = 1'b0;
        case (r_state)
            dbs_pkg::ST_LOAD: begin
                busy   = 1'b0;
                w_emit = 1'b0;
            end
            dbs_pkg::ST_EMIT: begin
                busy   = 1'b1;
                w_emit = 1'b1;
            end
            default: begin
                busy   = 1'b0;
                w_emit = 1'b0;
            end
        endcase
        w_ctl.insert = w_accept && w_room;
        w_ctl.shift  = w_emit;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dbs_pkg::ST_LOAD: begin
                if (w_accept && i_last) begin
                    n_state = dbs_pkg::ST_EMIT;
                end
            end
            dbs_pkg::ST_EMIT: begin
                if (!w_valid[1]) begin
                    n_state = dbs_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = dbs_pkg::ST_LOAD;
            end
        endcase
    end

    // fill count and dropped flag
    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        if (w_emit && !w_valid[1]) begin
            n_count   = '0;
            n_dropped = 1'b0;
        end else if (w_accept) begin
            if (w_room) begin
                n_count = r_count + 1'b1;
            end else begin
                n_dropped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dbs_pkg::ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // chain of cells, slot 0 holds the largest word
    for (genvar g = 0; g < dbs_pkg::DEPTH; g++) begin : g_cell
        logic signed [dbs_pkg::DATA_W-1:0] w_prev_value;
        logic                              w_prev_valid;
        logic                              w_prev_take;
        logic signed [dbs_pkg::DATA_W-1:0] w_next_value;
        logic                              w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_value = i_value;
            assign w_prev_valid = 1'b1;
            assign w_prev_take  = 1'b0;
        end else begin : g_body
            assign w_prev_value = w_value[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_take  = w_take[g-1];
        end

        if (g == dbs_pkg::DEPTH - 1) begin : g_tail
            assign w_next_value = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_value = w_value[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        dbs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new_value  (i_value),
            .i_prev_value (w_prev_value),
            .i_prev_valid (w_prev_valid),
            .i_prev_take  (w_prev_take),
            .i_next_value (w_next_value),
            .i_next_valid (w_next_valid),
            .o_value      (w_value[g]),
            .o_valid      (w_valid[g]),
            .o_take       (w_take[g])
        );
    end

    // result word comes straight from slot 0
    assign o_res_valid = w_emit;
    assign o_value_res = w_value[0];
    assign o_last_res  = w_emit && !w_valid[1];
    assign o_overflow  = r_dropped;

    // checks on the control logic
    a_close_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> (busy && o_res_valid))
        else $error("closing word did not start emission");

    a_last_ends_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_last_res) |=> (!busy && !o_overflow))
        else $error("emission did not end after final word");

    a_emit_slot_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> w_valid[0])
        else $error("result taken from an empty slot");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dbs_pkg::CNT_W'(dbs_pkg::DEPTH))
        else $error("fill count past capacity");

    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_last_res) |=> $stable(o_overflow))
        else $error("overflow flag changed within a batch");

endmodule
